/* hdl/cvsq_pkg.sv */
// Shared types and constants for the convex vertex support query block.
// Has no dependencies. The interfaces, the multiply-accumulate unit and the top level use it.
`default_nettype none

package cvsq_pkg;

	localparam int COORD_W = 32;
	localparam int INDEX_W = 6;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int ACC_W   = PROD_W + 2;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vertex_t;

	typedef struct packed {
		logic                      command;
		logic                      restart;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} cmd_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic [INDEX_W-1:0]        max_index;
		logic [INDEX_W-1:0]        min_index;
		logic                      empty_res;
		logic                      overflow;
	} res_item_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic    prod_en;
		acc_op_t acc_op;
	} mac_ctl_t;

endpackage

`default_nettype wire

/* hdl/cvsq_if.sv */
// Valid/ready channel interfaces for command items and result items.
// Depends on cvsq_pkg for the payload types.
`default_nettype none

interface cvsq_cmd_if;
	logic                  valid;
	logic                  ready;
	cvsq_pkg::cmd_item_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cvsq_res_if;
	logic                  valid;
	logic                  ready;
	cvsq_pkg::res_item_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/cvsq_mac.sv */
// Shared signed 32x32 multiplier with a registered product and a wide accumulator.
// Depends on cvsq_pkg for widths and the control struct.
`default_nettype none

module cvsq_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire cvsq_pkg::mac_ctl_t                   ctl,
	input  wire logic signed [cvsq_pkg::COORD_W-1:0]  op_a,
	input  wire logic signed [cvsq_pkg::COORD_W-1:0]  op_b,
	output logic signed [cvsq_pkg::ACC_W-1:0]         acc
);

	logic signed [cvsq_pkg::PROD_W-1:0] prod_q;
	logic signed [cvsq_pkg::ACC_W-1:0]  prod_ext;
	logic signed [cvsq_pkg::ACC_W-1:0]  acc_q;

	assign prod_ext = {{(cvsq_pkg::ACC_W - cvsq_pkg::PROD_W){prod_q[cvsq_pkg::PROD_W-1]}}, prod_q};
	assign acc      = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.prod_en) begin
			prod_q <= op_a * op_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (ctl.acc_op)
				cvsq_pkg::ACC_LOAD: acc_q <= prod_ext;
				cvsq_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
				default:            acc_q <= acc_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/convex_vertex_support_query_top.sv */
// Top level of the convex vertex support query block: vertex table, sequencer and result register.
// Depends on cvsq_pkg, the interfaces in cvsq_if and the shared unit cvsq_mac.
//
//   Channel   Role    Carries
//   cmd       sink    command, restart, coord_x, coord_y, coord_z
//   res       source  max/min vertex, max/min index, empty_res, overflow
//
// A query walks the stored vertices one at a time with the one shared multiplier:
// each vertex needs a table read, three products, a final add and a compare. An empty
// table goes straight to the result register.
// Reset empties the table and clears the dropped flag; the table itself is not cleared.
// The block takes no command while a query runs, and a query result waits in the output
// register until the result transfer completes.
`default_nettype none

module convex_vertex_support_query_top #(
	parameter int MAX_VERTICES = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cvsq_cmd_if.sink    cmd,
	cvsq_res_if.source  res
);

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = IDX_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MX,
		S_MY,
		S_MZ,
		S_ADD,
		S_CMP,
		S_OUT
	} state_t;

	state_t                                  state_q;
	logic [CNT_W-1:0]                        count_q;
	logic                                    dropped_q;
	logic [IDX_W-1:0]                        idx_q;
	cvsq_pkg::vertex_t                       dir_q;
	cvsq_pkg::vertex_t                       rd_q;
	cvsq_pkg::vertex_t                       max_v_q;
	cvsq_pkg::vertex_t                       min_v_q;
	logic [IDX_W-1:0]                        max_idx_q;
	logic [IDX_W-1:0]                        min_idx_q;
	logic signed [cvsq_pkg::ACC_W-1:0]       max_acc_q;
	logic signed [cvsq_pkg::ACC_W-1:0]       min_acc_q;
	logic                                    empty_q;
	logic                                    res_valid_q;
	cvsq_pkg::res_item_t                     res_q;

	cvsq_pkg::vertex_t                       mem [MAX_VERTICES];

	logic                                    cmd_xfer;
	logic                                    do_append;
	logic                                    wr_en;
	logic [IDX_W-1:0]                        wr_addr;
	cvsq_pkg::mac_ctl_t                      mac_ctl;
	logic signed [cvsq_pkg::COORD_W-1:0]     mul_a;
	logic signed [cvsq_pkg::COORD_W-1:0]     mul_b;
	logic signed [cvsq_pkg::ACC_W-1:0]       acc;
	logic                                    first_vtx;
	logic                                    last_vtx;
	logic [IDX_W+cvsq_pkg::INDEX_W-1:0]      max_idx_ext;
	logic [IDX_W+cvsq_pkg::INDEX_W-1:0]      min_idx_ext;

	assign cmd.ready   = (state_q == S_IDLE);
	assign cmd_xfer    = cmd.valid && cmd.ready;
	assign do_append   = cmd_xfer && (cmd.payload.command == cvsq_pkg::CMD_APPEND);
	assign wr_en       = do_append && (cmd.payload.restart || (count_q < CNT_W'(MAX_VERTICES)));
	assign wr_addr     = cmd.payload.restart ? '0 : count_q[IDX_W-1:0];
	assign first_vtx   = (idx_q == '0);
	assign last_vtx    = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign max_idx_ext = {{cvsq_pkg::INDEX_W{1'b0}}, max_idx_q};
	assign min_idx_ext = {{cvsq_pkg::INDEX_W{1'b0}}, min_idx_q};

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	always_comb begin
		mac_ctl.prod_en = 1'b0;
		mac_ctl.acc_op  = cvsq_pkg::ACC_HOLD;
		mul_a           = dir_q.x;
		mul_b           = rd_q.x;
		case (state_q)
			S_MX: begin
				mac_ctl.prod_en = 1'b1;
			end
			S_MY: begin
				mac_ctl.prod_en = 1'b1;
				mac_ctl.acc_op  = cvsq_pkg::ACC_LOAD;
				mul_a           = dir_q.y;
				mul_b           = rd_q.y;
			end
			S_MZ: begin
				mac_ctl.prod_en = 1'b1;
				mac_ctl.acc_op  = cvsq_pkg::ACC_ADD;
				mul_a           = dir_q.z;
				mul_b           = rd_q.z;
			end
			S_ADD: begin
				mac_ctl.acc_op  = cvsq_pkg::ACC_ADD;
			end
			default: begin
				mac_ctl.prod_en = 1'b0;
			end
		endcase
	end

	cvsq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.acc    (acc)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{x: cmd.payload.coord_x, y: cmd.payload.coord_y,
				z: cmd.payload.coord_z};
		end
		if (state_q == S_READ) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			idx_q       <= '0;
			dir_q       <= '0;
			max_v_q     <= '0;
			min_v_q     <= '0;
			max_idx_q   <= '0;
			min_idx_q   <= '0;
			max_acc_q   <= '0;
			min_acc_q   <= '0;
			empty_q     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && res.ready && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (do_append) begin
						if (cmd.payload.restart) begin
							count_q   <= CNT_W'(1);
							dropped_q <= 1'b0;
						end else if (count_q < CNT_W'(MAX_VERTICES)) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
					end else if (cmd_xfer) begin
						dir_q <= '{x: cmd.payload.coord_x, y: cmd.payload.coord_y,
							z: cmd.payload.coord_z};
						idx_q <= '0;
						if (count_q == '0) begin
							empty_q   <= 1'b1;
							max_v_q   <= '0;
							min_v_q   <= '0;
							max_idx_q <= '0;
							min_idx_q <= '0;
							state_q   <= S_OUT;
						end else begin
							empty_q <= 1'b0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_MX;
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_MZ;
				S_MZ:   state_q <= S_ADD;
				S_ADD:  state_q <= S_CMP;
				S_CMP: begin
					if (first_vtx || (acc > max_acc_q)) begin
						max_acc_q <= acc;
						max_v_q   <= rd_q;
						max_idx_q <= idx_q;
					end
					if (first_vtx || (acc < min_acc_q)) begin
						min_acc_q <= acc;
						min_v_q   <= rd_q;
						min_idx_q <= idx_q;
					end
					if (last_vtx) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_OUT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q     <= 1'b1;
						res_q.max_x     <= max_v_q.x;
						res_q.max_y     <= max_v_q.y;
						res_q.max_z     <= max_v_q.z;
						res_q.min_x     <= min_v_q.x;
						res_q.min_y     <= min_v_q.y;
						res_q.min_z     <= min_v_q.z;
						res_q.max_index <= max_idx_ext[cvsq_pkg::INDEX_W-1:0];
						res_q.min_index <= min_idx_ext[cvsq_pkg::INDEX_W-1:0];
						res_q.empty_res <= empty_q;
						res_q.overflow  <= dropped_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
